// ===== sv/spa_pkg.sv =====
// Shared types and constants of the sparse polynomial adder.
package spa_pkg;

  localparam int COEF_W  = 32;
  localparam int EXPON_W = 16;
  localparam int TERM_W  = COEF_W + EXPON_W;

  // Command codes as they arrive on the opcode field
  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic signed [COEF_W-1:0]  coef;
    logic        [EXPON_W-1:0] expon;
  } cmd_t;

  // Head of the command queue as seen by the execution side
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

endpackage

// ===== sv/spa_term_if.sv =====
// Input channel: one command word per handshake.
interface spa_term_if;
  import spa_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic signed [COEF_W-1:0]  term_coef;
  logic        [EXPON_W-1:0] term_expon;

  modport source (output valid, output opcode, output term_coef, output term_expon,
                  input ready);
  modport sink   (input valid, input opcode, input term_coef, input term_expon,
                  output ready);
endinterface

// ===== sv/spa_sum_if.sv =====
// Output channel: one result term word per handshake.
interface spa_sum_if;
  import spa_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COEF_W-1:0]  sum_coef;
  logic        [EXPON_W-1:0] sum_expon;
  logic                      last_term;
  logic                      empty_sum;
  logic                      overflow_error;

  modport source (output valid, output sum_coef, output sum_expon, output last_term,
                  output empty_sum, output overflow_error, input ready);
  modport sink   (input valid, input sum_coef, input sum_expon, input last_term,
                  input empty_sum, input overflow_error, output ready);
endinterface

// ===== sv/sparse_polynomial_add_core.sv =====
// Sparse polynomial adder: loads two descending-exponent term lists of up to
// TERMS_PER_LIST terms each (one load or clear word per cycle while no merge
// runs) and, on a compute word, streams the sum's terms in descending exponent
// order with saturating Q16.16 coefficient adds, cancelled terms dropped, the
// final word marked last and a single empty word when nothing remains. Words
// pass through a two-entry command queue, so up to two words are taken while
// the merge or the output stalls. A compute is dispatched from idle, then the
// sequencer runs one merge step for each emitted or cancelled term pair (at
// most na + nb) and a closing step, reading one entry of each list memory per
// step; output stalls hold the merge. The output word is held one term back to
// know which is last. Loads beyond capacity are dropped and flagged on
// overflow_error until a clear. No clearing pass follows reset.
module sparse_polynomial_add_core #(
  parameter int TERMS_PER_LIST = 32
) (
  input  logic       clk,
  input  logic       rst,
  spa_term_if.sink   term_in,
  spa_sum_if.source  sum_out
);
  import spa_pkg::*;

  cmd_head_t head;
  logic      cmd_pop;

  spa_front u_front (
    .clk     (clk),
    .rst     (rst),
    .term_in (term_in),
    .cmd_pop (cmd_pop),
    .head    (head)
  );

  spa_back #(.TERMS_PER_LIST(TERMS_PER_LIST)) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .cmd_pop (cmd_pop),
    .sum_out (sum_out)
  );

endmodule

// ===== sv/spa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module spa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/spa_front.sv =====
// Front end: accepts command words, decodes them and queues them for execution.
module spa_front (
  input  logic               clk,
  input  logic               rst,
  spa_term_if.sink           term_in,
  input  logic               cmd_pop,
  output spa_pkg::cmd_head_t head
);
  import spa_pkg::*;

  localparam int QDEPTH = 2;

  cmd_t       q [QDEPTH];
  logic [0:0] wp;
  logic [0:0] rp;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  cmd_t       dec;

  // Decode the incoming word into a command
  always_comb begin
    dec.op    = op_t'(term_in.opcode);
    dec.coef  = term_in.term_coef;
    dec.expon = term_in.term_expon;
  end

  assign term_in.ready = (fill != 2'(QDEPTH));
  assign push          = term_in.valid && term_in.ready;
  assign pop           = cmd_pop && head.valid;

  assign head.valid = (fill != 2'd0);
  assign head.cmd   = q[rp];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= dec;
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== sv/spa_back.sv =====
// Back end: holds both term lists and runs loads, clears and the merge sequencer.
module spa_back #(
  parameter int TERMS_PER_LIST = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  spa_pkg::cmd_head_t head,
  output logic               cmd_pop,
  spa_sum_if.source          sum_out
);
  import spa_pkg::*;

  localparam int AW = (TERMS_PER_LIST > 1) ? $clog2(TERMS_PER_LIST) : 1;
  localparam int CW = $clog2(TERMS_PER_LIST + 1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_MERGE = 2'b10
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] cnt_a, cnt_a_next;
  logic [CW-1:0] cnt_b, cnt_b_next;
  logic          ovf, ovf_next;
  logic [CW-1:0] ia, ia_next;
  logic [CW-1:0] ib, ib_next;

  // Pending term: held back until we know whether it is the last one
  logic                      pend_v, pend_v_next;
  logic signed [COEF_W-1:0]  pend_coef, pend_coef_next;
  logic        [EXPON_W-1:0] pend_expon, pend_expon_next;

  // Output register
  logic                      out_valid, out_valid_next;
  logic signed [COEF_W-1:0]  out_coef, out_coef_next;
  logic        [EXPON_W-1:0] out_expon, out_expon_next;
  logic                      out_last, out_last_next;
  logic                      out_empty, out_empty_next;
  logic                      out_ovf, out_ovf_next;

  logic              we_a, we_b;
  logic [TERM_W-1:0] rd_a, rd_b;
  logic [TERM_W-1:0] wdata;

  logic signed [COEF_W-1:0]  a_coef, b_coef, sat_coef;
  logic        [EXPON_W-1:0] a_expon, b_expon;
  logic signed [COEF_W:0]    raw_sum;
  logic                      a_v, b_v, out_free;
  logic                      nt_v, fin, adv_a, adv_b, need_push;
  logic signed [COEF_W-1:0]  nt_coef;
  logic        [EXPON_W-1:0] nt_expon;

  assign wdata = {head.cmd.coef, head.cmd.expon};

  // Read addresses follow the next index so data lines up with the index register
  spa_ram #(.WIDTH(TERM_W), .DEPTH(TERMS_PER_LIST)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a[AW-1:0]),
    .wdata (wdata),
    .raddr (ia_next[AW-1:0]),
    .rdata (rd_a)
  );

  spa_ram #(.WIDTH(TERM_W), .DEPTH(TERMS_PER_LIST)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b[AW-1:0]),
    .wdata (wdata),
    .raddr (ib_next[AW-1:0]),
    .rdata (rd_b)
  );

  assign a_coef  = $signed(rd_a[TERM_W-1 -: COEF_W]);
  assign a_expon = rd_a[EXPON_W-1:0];
  assign b_coef  = $signed(rd_b[TERM_W-1 -: COEF_W]);
  assign b_expon = rd_b[EXPON_W-1:0];

  // Saturating add of equal-exponent coefficients
  assign raw_sum  = {a_coef[COEF_W-1], a_coef} + {b_coef[COEF_W-1], b_coef};
  assign sat_coef = (raw_sum[COEF_W] != raw_sum[COEF_W-1]) ?
                    (raw_sum[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}}
                                     : {1'b0, {(COEF_W-1){1'b1}}}) :
                    raw_sum[COEF_W-1:0];

  assign a_v      = (ia < cnt_a);
  assign b_v      = (ib < cnt_b);
  assign out_free = !out_valid || sum_out.ready;

  // Merge step selection
  always_comb begin
    nt_v     = 1'b0;
    nt_coef  = a_coef;
    nt_expon = a_expon;
    adv_a    = 1'b0;
    adv_b    = 1'b0;
    fin      = 1'b0;
    if (a_v && b_v) begin
      if (a_expon < b_expon) begin
        nt_v     = 1'b1;
        nt_coef  = b_coef;
        nt_expon = b_expon;
        adv_b    = 1'b1;
      end else if (a_expon > b_expon) begin
        nt_v  = 1'b1;
        adv_a = 1'b1;
      end else begin
        nt_v    = (sat_coef != '0);
        nt_coef = sat_coef;
        adv_a   = 1'b1;
        adv_b   = 1'b1;
      end
    end else if (a_v) begin
      nt_v  = 1'b1;
      adv_a = 1'b1;
    end else if (b_v) begin
      nt_v     = 1'b1;
      nt_coef  = b_coef;
      nt_expon = b_expon;
      adv_b    = 1'b1;
    end else begin
      fin = 1'b1;
    end
    need_push = fin || (nt_v && pend_v);
  end

  // Command execution and sequencing
  always_comb begin
    state_next      = state;
    cnt_a_next      = cnt_a;
    cnt_b_next      = cnt_b;
    ovf_next        = ovf;
    ia_next         = ia;
    ib_next         = ib;
    pend_v_next     = pend_v;
    pend_coef_next  = pend_coef;
    pend_expon_next = pend_expon;
    out_valid_next  = out_valid && !sum_out.ready;
    out_coef_next   = out_coef;
    out_expon_next  = out_expon;
    out_last_next   = out_last;
    out_empty_next  = out_empty;
    out_ovf_next    = out_ovf;
    we_a            = 1'b0;
    we_b            = 1'b0;
    cmd_pop         = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (head.valid) begin
          cmd_pop = 1'b1;
          unique case (head.cmd.op)
            OP_LOAD_A: begin
              if (cnt_a == CW'(TERMS_PER_LIST)) begin
                ovf_next = 1'b1;
              end else begin
                we_a       = 1'b1;
                cnt_a_next = cnt_a + CW'(1);
              end
            end
            OP_LOAD_B: begin
              if (cnt_b == CW'(TERMS_PER_LIST)) begin
                ovf_next = 1'b1;
              end else begin
                we_b       = 1'b1;
                cnt_b_next = cnt_b + CW'(1);
              end
            end
            OP_COMPUTE: begin
              ia_next     = '0;
              ib_next     = '0;
              pend_v_next = 1'b0;
              state_next  = ST_MERGE;
            end
            OP_CLEAR: begin
              cnt_a_next = '0;
              cnt_b_next = '0;
              ovf_next   = 1'b0;
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      ST_MERGE: begin
        if (!need_push || out_free) begin
          if (adv_a) begin
            ia_next = ia + CW'(1);
          end
          if (adv_b) begin
            ib_next = ib + CW'(1);
          end
          if (nt_v) begin
            // A newer term proves the pending one is not last
            if (pend_v) begin
              out_valid_next = 1'b1;
              out_coef_next  = pend_coef;
              out_expon_next = pend_expon;
              out_last_next  = 1'b0;
              out_empty_next = 1'b0;
              out_ovf_next   = ovf;
            end
            pend_v_next     = 1'b1;
            pend_coef_next  = nt_coef;
            pend_expon_next = nt_expon;
          end
          if (fin) begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b1;
            out_ovf_next   = ovf;
            if (pend_v) begin
              out_coef_next  = pend_coef;
              out_expon_next = pend_expon;
              out_empty_next = 1'b0;
            end else begin
              out_coef_next  = '0;
              out_expon_next = '0;
              out_empty_next = 1'b1;
            end
            pend_v_next = 1'b0;
            state_next  = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt_a     <= '0;
      cnt_b     <= '0;
      ovf       <= 1'b0;
      ia        <= '0;
      ib        <= '0;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt_a     <= cnt_a_next;
      cnt_b     <= cnt_b_next;
      ovf       <= ovf_next;
      ia        <= ia_next;
      ib        <= ib_next;
      pend_v    <= pend_v_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_coef  <= pend_coef_next;
    pend_expon <= pend_expon_next;
    out_coef   <= out_coef_next;
    out_expon  <= out_expon_next;
    out_last   <= out_last_next;
    out_empty  <= out_empty_next;
    out_ovf    <= out_ovf_next;
  end

  assign sum_out.valid          = out_valid;
  assign sum_out.sum_coef       = out_coef;
  assign sum_out.sum_expon      = out_expon;
  assign sum_out.last_term      = out_last;
  assign sum_out.empty_sum      = out_empty;
  assign sum_out.overflow_error = out_ovf;

`ifndef ASSERT_OFF
  // Fill counts never pass the list capacity
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (cnt_a <= CW'(TERMS_PER_LIST)) && (cnt_b <= CW'(TERMS_PER_LIST)))
    else $error("list count beyond capacity");

  // Merge indices stay within the loaded terms
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MERGE) |-> ((ia <= cnt_a) && (ib <= cnt_b)))
    else $error("merge index beyond list count");

  // No command is taken while a merge runs
  a_no_pop_merge: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MERGE) |-> !cmd_pop)
    else $error("command popped during merge");

  // A held term exists only inside a merge
  a_pend_merge: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> (state == ST_MERGE))
    else $error("pending term outside merge");

  // An empty-sum word is last and carries zero fields
  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_empty) |-> (out_last && (out_coef == '0) && (out_expon == '0)))
    else $error("malformed empty-sum word");

  // Lists are not loaded or cleared while a merge reads them
  a_counts_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MERGE) |=> ($stable(cnt_a) && $stable(cnt_b)))
    else $error("list count changed during merge");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the sparse polynomial adder core: directed table, then random merges.
module tb_top;
  import spa_pkg::*;

  localparam int TERMS        = 32;
  localparam int TOTAL_WORDS  = 410;
  localparam int PHASE_WORDS  = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_PRINTS   = 40;
  localparam longint TIMEOUT_NS = 64'd10_000_000;
  localparam int LIST_A = 0;
  localparam int LIST_B = 1;
  localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [COEF_W-1:0]  coef;
    logic        [EXPON_W-1:0] expon;
  } term_t;

  // One result word as it leaves the block
  typedef struct packed {
    logic signed [COEF_W-1:0]  coef;
    logic        [EXPON_W-1:0] expon;
    logic                      last;
    logic                      empty;
    logic                      ovf;
  } sum_word_t;

  // Per input word: optional hand-written expectation for a one-word sum
  typedef struct packed {
    logic      fixed;
    sum_word_t want;
  } word_note_t;

  typedef struct packed {
    op_t                       op;
    logic signed [COEF_W-1:0]  coef;
    logic        [EXPON_W-1:0] expon;
    logic                      fixed;
    sum_word_t                 want;
  } stim_row_t;

  typedef enum logic [1:0] {
    PH_STEADY    = 2'd0,
    PH_SRC_IDLE  = 2'd1,
    PH_SNK_STALL = 2'd2,
    PH_BOTH      = 2'd3
  } pace_t;

  localparam sum_word_t NO_WORD   = '0;
  localparam sum_word_t EMPTY_SUM = '{'0, '0, 1'b1, 1'b1, 1'b0};

  logic clk = 1'b0;
  logic rst;

  spa_term_if term_if ();
  spa_sum_if  sum_if ();

  sparse_polynomial_add_core #(.TERMS_PER_LIST(TERMS)) dut (
    .clk     (clk),
    .rst     (rst),
    .term_in (term_if),
    .sum_out (sum_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the two term lists
  term_t list_terms [2][TERMS];
  int    list_count [2];
  bit    load_ovf;

  sum_word_t  sum_due [$];
  word_note_t word_notes [$];
  stim_row_t  stim_rows [$];

  pace_t pace = PH_BOTH;
  bit    hold_pending = 1'b0;
  int    mismatches = 0;
  int    words_sent = 0;
  int    sums_taken = 0;
  int    loads_dropped = 0;
  int    words_checked = 0;
  int    holds_done = 0;

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  function automatic bit src_gap();
    case (pace)
      PH_SRC_IDLE: return $urandom_range(99) < 75;
      PH_BOTH:     return $urandom_range(99) < 19;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit snk_stall();
    case (pace)
      PH_SNK_STALL: return $urandom_range(99) < 75;
      PH_BOTH:      return $urandom_range(99) < 19;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic sum_word_t term_word(input term_t t);
    sum_word_t w;
    w = '{t.coef, t.expon, 1'b0, 1'b0, load_ovf};
    return w;
  endfunction

  // Merge both lists into the expected sum, descending exponent order
  task automatic merge_lists();
    sum_word_t w [$];
    term_t     ta, tb_term;
    int        ia, ib, na, nb;
    longint    s;
    ia = 0;
    ib = 0;
    na = (list_count[LIST_A] > TERMS) ? TERMS : list_count[LIST_A];
    nb = (list_count[LIST_B] > TERMS) ? TERMS : list_count[LIST_B];
    while (ia < na && ib < nb) begin
      ta      = list_terms[LIST_A][ia];
      tb_term = list_terms[LIST_B][ib];
      if (ta.expon < tb_term.expon) begin
        w.push_back(term_word(tb_term));
        ib++;
      end else if (ta.expon > tb_term.expon) begin
        w.push_back(term_word(ta));
        ia++;
      end else begin
        s = ta.coef;
        s += tb_term.coef;
        if (s > longint'(COEF_MAX)) s = COEF_MAX;
        if (s < longint'(COEF_MIN)) s = COEF_MIN;
        // cancelled terms vanish
        if (s != 0) w.push_back('{s[COEF_W-1:0], ta.expon, 1'b0, 1'b0, load_ovf});
        ia++;
        ib++;
      end
    end
    for (; ia < na; ia++) w.push_back(term_word(list_terms[LIST_A][ia]));
    for (; ib < nb; ib++) w.push_back(term_word(list_terms[LIST_B][ib]));
    if (w.size() == 0) w.push_back('{'0, '0, 1'b0, 1'b1, load_ovf});
    w[w.size()-1].last = 1'b1;
    foreach (w[i]) sum_due.push_back(w[i]);
  endtask

  // Predictor step for one accepted input word
  task automatic take_word();
    word_note_t note;
    op_t        op;
    int         id;
    term_t      t;
    sum_word_t  scratch [$];
    note = word_notes.size() ? word_notes.pop_front() : '0;
    op = op_t'(term_if.opcode);
    t  = '{term_if.term_coef, term_if.term_expon};
    case (op) inside
      OP_LOAD_A, OP_LOAD_B: begin
        id = (op == OP_LOAD_A) ? LIST_A : LIST_B;
        if (list_count[id] >= TERMS) begin
          load_ovf = 1'b1;
          loads_dropped++;
        end else begin
          list_terms[id][list_count[id]] = t;
          list_count[id]++;
        end
      end
      OP_CLEAR: begin
        list_count[LIST_A] = 0;
        list_count[LIST_B] = 0;
        load_ovf = 1'b0;
      end
      default: begin
        sums_taken++;
        if (note.fixed) begin
          // state is not changed by a compute, so the typed word replaces the merge
          scratch = sum_due;
          merge_lists();
          sum_due = scratch;
          sum_due.push_back(note.want);
        end else begin
          merge_lists();
        end
      end
    endcase
  endtask

  task automatic check_word();
    sum_word_t got, want;
    got = '{sum_if.sum_coef, sum_if.sum_expon, sum_if.last_term, sum_if.empty_sum,
            sum_if.overflow_error};
    words_checked++;
    if (sum_due.size() == 0) begin
      note_mismatch($sformatf("result word %h with nothing expected", got));
      return;
    end
    want = sum_due.pop_front();
    if (got.coef !== want.coef)
      note_mismatch($sformatf("sum_coef %h, expected %h", got.coef, want.coef));
    if (got.expon !== want.expon)
      note_mismatch($sformatf("sum_expon %h, expected %h", got.expon, want.expon));
    if (got.last !== want.last)
      note_mismatch($sformatf("last_term %b, expected %b", got.last, want.last));
    if (got.empty !== want.empty)
      note_mismatch($sformatf("empty_sum %b, expected %b", got.empty, want.empty));
    if (got.ovf !== want.ovf)
      note_mismatch($sformatf("overflow_error %b, expected %b", got.ovf, want.ovf));
  endtask

  // Both channels sampled at the edge, input side first
  always @(posedge clk) begin
    if (!rst) begin
      if (term_if.valid && term_if.ready) take_word();
      if (sum_if.valid && sum_if.ready) check_word();
    end
  end

  // Result receiver, with one long hold-off on request
  initial begin
    sum_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        repeat (HOLD_CYCLES) begin
          sum_if.ready <= 1'b0;
          @(posedge clk);
        end
        holds_done++;
      end
      sum_if.ready <= !snk_stall();
      @(posedge clk);
    end
  end

  task automatic send_word(input op_t op, input logic signed [COEF_W-1:0] coef,
                           input logic [EXPON_W-1:0] expon, input logic fixed,
                           input sum_word_t want);
    while (src_gap()) begin
      term_if.valid <= 1'b0;
      @(posedge clk);
    end
    term_if.valid      <= 1'b1;
    term_if.opcode     <= op;
    term_if.term_coef  <= coef;
    term_if.term_expon <= expon;
    word_notes.push_back('{fixed, want});
    do @(posedge clk); while (!term_if.ready);
    words_sent++;
  endtask

  function automatic logic signed [COEF_W-1:0] pick_coef();
    case ($urandom_range(7))
      4:       return COEF_MAX - $urandom_range(0, 3);
      5:       return COEF_MIN + $urandom_range(0, 3);
      6:       return $signed($urandom_range(0, 511)) - 256;
      7:       return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(0, 6);
    if (r < 90) return $urandom_range(7, 20);
    return $urandom_range(28, 36);
  endfunction

  function automatic int expon_step(input bit dense);
    return dense ? $urandom_range(1, 2) : $urandom_range(1, 1800);
  endfunction

  // One random sequence: mostly clear, two sorted lists, compute; sometimes noise
  task automatic run_sequence();
    term_t la [$], lb [$];
    term_t t;
    int    na, nb, ia, ib;
    bit    dense, messy;
    logic [EXPON_W-1:0] e;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 6))
        send_word(op_t'(2'($urandom_range(0, 3))), $urandom, 16'($urandom), 1'b0, NO_WORD);
      return;
    end
    if ($urandom_range(9) < 8) send_word(OP_CLEAR, $urandom, 16'($urandom), 1'b0, NO_WORD);
    na    = pick_size();
    nb    = pick_size();
    dense = 1'($urandom_range(1));
    messy = ($urandom_range(19) == 0);
    e = dense ? 16'($urandom_range(80, 200)) : 16'($urandom_range(64800, 65535));
    for (int k = 0; k < na; k++) begin
      t.expon = messy ? 16'($urandom) : e;
      t.coef  = pick_coef();
      la.push_back(t);
      e -= 16'(expon_step(dense));
    end
    e = dense ? 16'($urandom_range(80, 200)) : 16'($urandom_range(64800, 65535));
    for (int k = 0; k < nb; k++) begin
      t.expon = messy ? 16'($urandom) : e;
      t.coef  = pick_coef();
      // steer matching exponents toward cancellation and saturation
      foreach (la[j]) begin
        if (la[j].expon == t.expon) begin
          case ($urandom_range(3))
            0: t.coef = -la[j].coef;
            1: t.coef = la[j].coef[COEF_W-1] ? COEF_MIN : COEF_MAX;
            default: ;
          endcase
        end
      end
      lb.push_back(t);
      e -= 16'(expon_step(dense));
    end
    ia = 0;
    ib = 0;
    while (ia < na || ib < nb) begin
      if (ib >= nb || (ia < na && $urandom_range(1))) begin
        send_word(OP_LOAD_A, la[ia].coef, la[ia].expon, 1'b0, NO_WORD);
        ia++;
      end else begin
        send_word(OP_LOAD_B, lb[ib].coef, lb[ib].expon, 1'b0, NO_WORD);
        ib++;
      end
    end
    send_word(OP_COMPUTE, $urandom, 16'($urandom), 1'b0, NO_WORD);
    if ($urandom_range(99) < 15) send_word(OP_COMPUTE, '0, '0, 1'b0, NO_WORD);
  endtask

  // Directed table: extremes, every command, saturation, cancellation, repeat
  initial begin
    stim_rows.push_back('{OP_COMPUTE, '0, '0, 1'b1, EMPTY_SUM});
    stim_rows.push_back('{OP_LOAD_A, COEF_MAX, 16'hFFFF, 1'b0, NO_WORD});
    stim_rows.push_back('{OP_LOAD_B, 32'sd1, 16'hFFFF, 1'b0, NO_WORD});
    stim_rows.push_back('{OP_COMPUTE, '0, '0, 1'b1, '{COEF_MAX, 16'hFFFF, 1'b1, 1'b0, 1'b0}});
    stim_rows.push_back('{OP_CLEAR, '0, '0, 1'b0, NO_WORD});
    stim_rows.push_back('{OP_LOAD_A, COEF_MIN, 16'h0000, 1'b0, NO_WORD});
    stim_rows.push_back('{OP_LOAD_B, -32'sd1, 16'h0000, 1'b0, NO_WORD});
    stim_rows.push_back('{OP_COMPUTE, '0, '0, 1'b1, '{COEF_MIN, 16'h0000, 1'b1, 1'b0, 1'b0}});
    stim_rows.push_back('{OP_CLEAR, '0, '0, 1'b0, NO_WORD});
    stim_rows.push_back('{OP_LOAD_A, 32'sh0001_0000, 16'd5, 1'b0, NO_WORD});
    stim_rows.push_back('{OP_LOAD_B, 32'shFFFF_0000, 16'd5, 1'b0, NO_WORD});
    stim_rows.push_back('{OP_COMPUTE, '0, '0, 1'b1, EMPTY_SUM});
    stim_rows.push_back('{OP_COMPUTE, '0, '0, 1'b1, EMPTY_SUM});
    // lists left unsorted on purpose
    stim_rows.push_back('{OP_LOAD_A, 32'sh1234_5678, 16'd9, 1'b0, NO_WORD});
    stim_rows.push_back('{OP_LOAD_B, 32'shEDCB_A988, 16'd7, 1'b0, NO_WORD});
    stim_rows.push_back('{OP_LOAD_A, 32'sh0000_ABCD, 16'hFFFF, 1'b0, NO_WORD});
    stim_rows.push_back('{OP_COMPUTE, '0, '0, 1'b0, NO_WORD});
    stim_rows.push_back('{OP_COMPUTE, '0, '0, 1'b0, NO_WORD});
    stim_rows.push_back('{OP_CLEAR, 32'shFFFF_FFFF, 16'hFFFF, 1'b0, NO_WORD});
    stim_rows.push_back('{OP_LOAD_B, 32'sd5, 16'd100, 1'b0, NO_WORD});
    stim_rows.push_back('{OP_COMPUTE, '0, '0, 1'b1, '{32'sd5, 16'd100, 1'b1, 1'b0, 1'b0}});
    stim_rows.push_back('{OP_LOAD_A, 32'sh5555_5555, 16'hAAAA, 1'b0, NO_WORD});
    stim_rows.push_back('{OP_LOAD_A, 32'shAAAA_AAAA, 16'h5555, 1'b0, NO_WORD});
    stim_rows.push_back('{OP_COMPUTE, '0, '0, 1'b0, NO_WORD});
    stim_rows.push_back('{OP_CLEAR, '0, '0, 1'b0, NO_WORD});
    stim_rows.push_back('{OP_COMPUTE, '0, '0, 1'b1, EMPTY_SUM});
  end

  // Main sequence: reset, directed rows, random sequences, drain
  initial begin
    list_count[LIST_A] = 0;
    list_count[LIST_B] = 0;
    load_ovf = 1'b0;
    rst <= 1'b1;
    term_if.valid      <= 1'b0;
    term_if.opcode     <= OP_LOAD_A;
    term_if.term_coef  <= '0;
    term_if.term_expon <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    pace = PH_BOTH;
    foreach (stim_rows[i])
      send_word(stim_rows[i].op, stim_rows[i].coef, stim_rows[i].expon, stim_rows[i].fixed,
                stim_rows[i].want);

    // long receiver hold-off while the sender keeps pushing
    pace = PH_STEADY;
    hold_pending = 1'b1;
    while (words_sent < TOTAL_WORDS) begin
      pace = pace_t'(2'((words_sent / PHASE_WORDS) % 4));
      run_sequence();
    end
    term_if.valid <= 1'b0;
    pace = PH_STEADY;

    while (sum_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sum_due.size() != 0) note_mismatch($sformatf("%0d result words never came", sum_due.size()));

    $display("Sent %0d input words with %0d sums; %0d loads dropped for a full list.",
             words_sent, sums_taken, loads_dropped);
    $display("Checked %0d result words across all pacing phases and %0d long output hold-off(s).",
             words_checked, holds_done);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Watchdog expired with %0d result words outstanding", sum_due.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sparse_polynomial_add_core.f =====
sv/spa_pkg.sv
sv/spa_term_if.sv
sv/spa_sum_if.sv
sv/spa_ram.sv
sv/spa_front.sv
sv/spa_back.sv
sv/sparse_polynomial_add_core.sv
verif/tb_top.sv
